FILE: hw/rtl/fbfl_pkg.sv
// Shared types, constants and helper functions of the free-list block allocator.
package fbfl_pkg;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 21;
  localparam int BC_W       = 9;
  localparam int FB_W       = 9;
  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int LIM_W      = CNT_W + SIZE_W;
  localparam int PROD_W     = IDX_W + SIZE_W;
  localparam int CMP_W      = (ADDR_W > LIM_W) ? ADDR_W : LIM_W;
  localparam int DIV_STEPS  = (IDX_W + 1) / 2;
  localparam int QDIV_W     = 2 * DIV_STEPS;
  localparam int DCNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [ADDR_W-1:0] BASE_RST = '0;
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(64);
  localparam logic [BC_W-1:0]   BC_RST   = BC_W'(256);

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CHECK,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    status_t           status;
    logic [FB_W-1:0]   free_blocks;
  } out_item_t;

  // Effective configuration seen by front and back
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  count;
    logic [LIM_W-1:0]  lim;
    logic              init;
  } cfg_t;

  // Classified list operation
  typedef struct packed {
    kind_t            kind;
    logic             ok;
    logic [IDX_W-1:0] idx;
  } op_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [BC_W-1:0] bc);
    logic [CNT_W-1:0] c;
    if (bc == '0) begin
      c = CNT_W'(1);
    end else if (int'(bc) > MAX_BLOCKS) begin
      c = CNT_W'(MAX_BLOCKS);
    end else begin
      c = CNT_W'(bc);
    end
    return c;
  endfunction

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    return (s == '0) ? SIZE_W'(1) : s;
  endfunction

endpackage

FILE: hw/rtl/fbfl_front.sv
// Front end: accepts requests, range-checks free addresses and divides them into block indexes.
module fbfl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fbfl_pkg::in_item_t  in_item,
  input  fbfl_pkg::cfg_t      cfg,
  input  fbfl_pkg::q_status_t q_stat,
  output logic                q_push,
  output fbfl_pkg::op_t       q_data
);

  fbfl_pkg::front_state_t            state_r, state_nxt;
  fbfl_pkg::kind_t                   kind_r;
  logic [fbfl_pkg::ADDR_W-1:0]       diff_r;
  logic [fbfl_pkg::LIM_W-1:0]        rem_r, rem_nxt;
  logic [fbfl_pkg::LIM_W-1:0]        dvs_r;
  logic [fbfl_pkg::QDIV_W-1:0]       quo_r, quo_nxt;
  logic [fbfl_pkg::DCNT_W-1:0]       step_r;
  logic                              ok_r;
  logic                              accept;
  logic                              out_of_range;
  logic                              b_hi, b_lo;
  logic [fbfl_pkg::LIM_W-1:0]        r_mid;
  logic [fbfl_pkg::LIM_W-1:0]        dvs_lo;

  assign accept       = start && (state_r == fbfl_pkg::FR_IDLE);
  assign out_of_range = fbfl_pkg::CMP_W'(diff_r) >= fbfl_pkg::CMP_W'(cfg.lim);

  // two restoring steps per cycle
  always_comb begin
    dvs_lo  = dvs_r >> 1;
    b_hi    = rem_r >= dvs_r;
    r_mid   = b_hi ? (rem_r - dvs_r) : rem_r;
    b_lo    = r_mid >= dvs_lo;
    rem_nxt = b_lo ? (r_mid - dvs_lo) : r_mid;
    quo_nxt = fbfl_pkg::QDIV_W'({quo_r, b_hi, b_lo});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbfl_pkg::FR_IDLE: begin
        if (accept) begin
          state_nxt = (in_item.kind == fbfl_pkg::KIND_FREE) ? fbfl_pkg::FR_CHECK
                                                            : fbfl_pkg::FR_PUSH;
        end
      end
      fbfl_pkg::FR_CHECK: begin
        state_nxt = out_of_range ? fbfl_pkg::FR_PUSH : fbfl_pkg::FR_DIV;
      end
      fbfl_pkg::FR_DIV: begin
        if (step_r == '0) state_nxt = fbfl_pkg::FR_PUSH;
      end
      fbfl_pkg::FR_PUSH: begin
        if (!q_stat.full) state_nxt = fbfl_pkg::FR_IDLE;
      end
      default: state_nxt = fbfl_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state_r != fbfl_pkg::FR_IDLE);
    q_push      = (state_r == fbfl_pkg::FR_PUSH) && !q_stat.full;
    q_data.kind = kind_r;
    q_data.ok   = (kind_r == fbfl_pkg::KIND_ALLOC) || ok_r;
    q_data.idx  = quo_r[fbfl_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbfl_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      fbfl_pkg::FR_IDLE: begin
        if (accept) begin
          kind_r <= in_item.kind;
          diff_r <= in_item.block_address - cfg.base;
        end
      end
      fbfl_pkg::FR_CHECK: begin
        ok_r   <= 1'b0;
        rem_r  <= fbfl_pkg::LIM_W'(diff_r);
        dvs_r  <= fbfl_pkg::LIM_W'(cfg.size) << (fbfl_pkg::QDIV_W - 1);
        quo_r  <= '0;
        step_r <= fbfl_pkg::DCNT_W'(fbfl_pkg::DIV_STEPS - 1);
      end
      fbfl_pkg::FR_DIV: begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        dvs_r  <= dvs_r >> 2;
        step_r <= step_r - 1'b1;
        if (step_r == '0) ok_r <= (rem_nxt == '0);
      end
      fbfl_pkg::FR_PUSH: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/fbfl_queue.sv
// Short op queue between front end and list engine.
module fbfl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fbfl_pkg::op_t       push_data,
  input  logic                pop,
  output fbfl_pkg::op_t       pop_data,
  output fbfl_pkg::q_status_t stat
);

  fbfl_pkg::op_t                slot_r [fbfl_pkg::QDEPTH];
  logic [fbfl_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [fbfl_pkg::QCNT_W-1:0]  fill_r;

  function automatic logic [fbfl_pkg::QPTR_W-1:0] ptr_inc(
    input logic [fbfl_pkg::QPTR_W-1:0] p
  );
    return (p == fbfl_pkg::QPTR_W'(fbfl_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full     = (fill_r == fbfl_pkg::QCNT_W'(fbfl_pkg::QDEPTH));
  assign stat.nonempty = (fill_r != '0);
  assign pop_data      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: hw/rtl/fbfl_back.sv
// List engine: owns the link memory, head and free count, and issues results.
module fbfl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fbfl_pkg::cfg_t      cfg,
  input  logic                q_nonempty,
  input  fbfl_pkg::op_t       q_data,
  output logic                q_pop,
  output logic                out_strobe,
  output fbfl_pkg::out_item_t out_item
);

  fbfl_pkg::back_state_t              state_r, state_nxt;
  fbfl_pkg::op_t                      op_r;
  logic [fbfl_pkg::IDX_W-1:0]         head_r, head_nxt;
  logic [fbfl_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [fbfl_pkg::IDX_W-1:0]         link_mem [fbfl_pkg::MAX_BLOCKS];
  logic [fbfl_pkg::IDX_W-1:0]         link_q;
  logic [fbfl_pkg::MAX_BLOCKS-1:0]    link_vld_r;
  logic [fbfl_pkg::PROD_W-1:0]        prod_r;
  logic                               link_we;
  logic [fbfl_pkg::IDX_W-1:0]         next_head;
  logic                               out_strobe_r;
  fbfl_pkg::out_item_t                out_item_r, out_item_nxt;

  // unwritten entries still hold the initial chain i -> i+1
  assign next_head = link_vld_r[head_r] ? link_q :
                     (head_r == fbfl_pkg::IDX_W'(fbfl_pkg::MAX_BLOCKS - 1)) ? '0 :
                     head_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbfl_pkg::BK_IDLE: if (q_nonempty && !cfg.init) state_nxt = fbfl_pkg::BK_EXEC;
      fbfl_pkg::BK_EXEC: state_nxt = fbfl_pkg::BK_IDLE;
      default:           state_nxt = fbfl_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = (state_r == fbfl_pkg::BK_IDLE) && q_nonempty && !cfg.init;
    link_we      = 1'b0;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    out_item_nxt.granted_address = '0;
    out_item_nxt.status          = fbfl_pkg::ST_OK;
    if (state_r == fbfl_pkg::BK_EXEC) begin
      if (op_r.kind == fbfl_pkg::KIND_ALLOC) begin
        if (cnt_r == '0) begin
          out_item_nxt.status = fbfl_pkg::ST_EMPTY;
        end else begin
          out_item_nxt.granted_address = cfg.base + fbfl_pkg::ADDR_W'(prod_r);
          head_nxt = next_head;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end else begin
        if (!op_r.ok) begin
          out_item_nxt.status = fbfl_pkg::ST_UNKNOWN;
        end else begin
          link_we  = 1'b1;
          head_nxt = op_r.idx;
          if (cnt_r < cfg.count) cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
    out_item_nxt.free_blocks = fbfl_pkg::FB_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fbfl_pkg::BK_IDLE;
      head_r       <= '0;
      cnt_r        <= fbfl_pkg::eff_count(fbfl_pkg::BC_RST);
      link_vld_r   <= '0;
      out_strobe_r <= 1'b0;
    end else if (cfg.init) begin
      state_r      <= fbfl_pkg::BK_IDLE;
      head_r       <= '0;
      cnt_r        <= cfg.count;
      link_vld_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= (state_r == fbfl_pkg::BK_EXEC);
      if (link_we) link_vld_r[op_r.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[op_r.idx] <= head_r;
    link_q <= link_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (q_pop) op_r <= q_data;
    prod_r <= head_r * cfg.size;
    if (state_r == fbfl_pkg::BK_EXEC) out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

FILE: hw/rtl/fixed_block_free_list_allocator_core.sv
// Top level of the fixed-size block free-list allocator: register port, front, queue, back.
//
// A pool of equal blocks starting at the base register is kept as a LIFO free
// list. Drive start with an item while busy is low: kind allocate pops the head
// block and returns its address, kind free maps block_address back to a block
// index and pushes it (addresses off the block grid or past the count return
// unknown-address status; double frees are not caught). Every item gives
// exactly one result, shown for one cycle with out_strobe; the receiver cannot
// hold it off. An allocate leaves busy high only until its op is pushed into
// the queue; a free first passes a range check and the offset-to-index
// division in the front end, which retires two quotient bits a cycle. Busy
// also stays high while the queue is full. A free whose offset lies past the
// end of the pool skips the division. Each op then passes the queue and the
// list engine's execute state, from which out_strobe is registered.
// The list engine handles one item at a time (registered read of the link
// memory) and pops the next only after it has executed the last. A two-entry
// queue decouples the two halves. Writing block_count rebuilds the list
// (per-entry valid bits); write configuration only while no item is in flight.
module fixed_block_free_list_allocator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  fbfl_pkg::in_item_t                  in_item,
  // result channel
  output logic                                out_strobe,
  output fbfl_pkg::out_item_t                 out_item,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fbfl_pkg::PADDR_W-1:0]        paddr,
  input  logic [fbfl_pkg::PDATA_W-1:0]        pwdata,
  output logic [fbfl_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [fbfl_pkg::ADDR_W-1:0] base_r;
  logic [fbfl_pkg::SIZE_W-1:0] size_r;
  logic [fbfl_pkg::BC_W-1:0]   count_r;
  logic                        init_r;
  logic [fbfl_pkg::LIM_W-1:0]  lim_r;
  logic                        wr_en;
  logic [1:0]                  reg_idx;
  fbfl_pkg::cfg_t              cfg;
  fbfl_pkg::q_status_t         q_stat;
  fbfl_pkg::op_t               q_in, q_out;
  logic                        q_push, q_pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= fbfl_pkg::BASE_RST;
      size_r  <= fbfl_pkg::SIZE_RST;
      count_r <= fbfl_pkg::BC_RST;
      init_r  <= 1'b0;
    end else begin
      // a count write rebuilds the list on the next cycle
      init_r <= wr_en && (reg_idx == fbfl_pkg::REG_COUNT);
      if (wr_en) begin
        unique case (reg_idx)
          fbfl_pkg::REG_BASE:  base_r  <= fbfl_pkg::ADDR_W'(pwdata);
          fbfl_pkg::REG_SIZE:  size_r  <= fbfl_pkg::SIZE_W'(pwdata);
          fbfl_pkg::REG_COUNT: count_r <= fbfl_pkg::BC_W'(pwdata);
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      fbfl_pkg::REG_BASE:  prdata = fbfl_pkg::PDATA_W'(base_r);
      fbfl_pkg::REG_SIZE:  prdata = fbfl_pkg::PDATA_W'(size_r);
      fbfl_pkg::REG_COUNT: prdata = fbfl_pkg::PDATA_W'(count_r);
      default:             prdata = '0;
    endcase
  end

  // pool span in bytes; a free offset at or past it is rejected before dividing
  always_ff @(posedge clk) begin
    lim_r <= fbfl_pkg::LIM_W'(fbfl_pkg::eff_count(count_r) * fbfl_pkg::eff_size(size_r));
  end

  always_comb begin
    cfg.base  = base_r;
    cfg.size  = fbfl_pkg::eff_size(size_r);
    cfg.count = fbfl_pkg::eff_count(count_r);
    cfg.lim   = lim_r;
    cfg.init  = init_r;
  end

  fbfl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  fbfl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  fbfl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_nonempty (q_stat.nonempty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

`ifndef SYNTH
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("op queue overflow");

  a_pop_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ##2 out_strobe)
    else $error("popped op produced no result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == fbfl_pkg::ST_EMPTY) |->
      (out_item.granted_address == '0 && out_item.free_blocks == '0))
    else $error("empty-pool result with nonzero fields");
`endif

endmodule
